[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/swhr_pkg.sv]
// Types and constants of the single-wire humidity sensor reader.
package swhr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAKE,
        PH_RELEASE,
        PH_RESP_LOW,
        PH_RESP_HIGH,
        PH_BIT_LOW,
        PH_BIT_HIGH
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PULSE    = 2'd1,
        ST_CHECKSUM = 2'd2,
        ST_HUM_ZERO = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_TIMEOUT   = 2'd0,
        CFG_START_LOW = 2'd1,
        CFG_RELEASE   = 2'd2
    } t_cfg_idx;

    localparam int FRAME_LEN = 40;
    localparam int BIT_IDX_W = 6;
    localparam int TICK_W    = 16;
    localparam int CFG_W     = 16;

    localparam logic [7:0]  TIMEOUT_RST   = 8'd255;
    localparam logic [15:0] START_LOW_RST = 16'd5000;
    localparam logic [7:0]  RELEASE_RST   = 8'd30;

    typedef struct packed {
        logic [7:0]  timeout;
        logic [15:0] start_low;
        logic [7:0]  release_len;
    } t_cfg;

    typedef struct packed {
        logic        drive_low;
        logic        busy;
        logic        done;
        t_status     status;
        logic [15:0] humidity;
        logic [15:0] temperature;
    } t_result;

endpackage

[rtl/swhr_decode.sv]
// Frame decoder: checksum, humidity and sign-magnitude temperature.
module swhr_decode import swhr_pkg::*; (
    input  logic [FRAME_LEN-1:0] i_frame,
    output t_status              o_status,
    output logic [15:0]          o_humidity,
    output logic [15:0]          o_temperature
);

    logic [7:0]  b0, b1, b2, b3, b4;
    logic [7:0]  sum;
    logic [15:0] mag;

    assign b0  = i_frame[39:32];
    assign b1  = i_frame[31:24];
    assign b2  = i_frame[23:16];
    assign b3  = i_frame[15:8];
    assign b4  = i_frame[7:0];
    assign sum = b0 + b1 + b2 + b3;
    assign mag = {1'b0, b2[6:0], b3};

    assign o_humidity    = {b0, b1};
    assign o_temperature = b2[7] ? (16'd0 - mag) : mag;

    always_comb begin
        if (sum != b4) begin
            o_status = ST_CHECKSUM;
        end else if (o_humidity == 16'd0) begin
            o_status = ST_HUM_ZERO;
        end else begin
            o_status = ST_OK;
        end
    end

endmodule

[rtl/swhr_ctrl.sv]
// Read sequencer: wake pulse, pulse timing, bit capture and result latch.
module swhr_ctrl import swhr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_line,
    input  logic    i_start,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    t_phase                r_phase, n_phase;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [7:0]            r_low_len, n_low_len;
    logic [BIT_IDX_W-1:0]  r_bit_idx, n_bit_idx;
    logic [FRAME_LEN-1:0]  r_frame, n_frame;
    logic [15:0]           r_hum, n_hum;
    logic [15:0]           r_temp, n_temp;

    t_phase                ph_eff;
    logic                  starting;
    logic [TICK_W-1:0]     tc_eff;
    logic [TICK_W:0]       tc_inc;
    logic                  in_pulse, level, same;
    logic                  first_fail, pulse_end, last_bit, second_fail, fail;
    logic [BIT_IDX_W-1:0]  bit_inc;
    logic [FRAME_LEN-1:0]  frame_next;
    t_status               dec_status;
    logic [15:0]           dec_hum, dec_temp;
    logic                  drive, done;
    t_status               status;

    assign starting = (r_phase == PH_IDLE) && i_start;
    assign ph_eff   = starting ? PH_WAKE : r_phase;
    assign tc_eff   = starting ? '0 : r_tick;
    assign tc_inc   = {1'b0, tc_eff} + 1'b1;

    assign in_pulse = (ph_eff == PH_RESP_LOW) || (ph_eff == PH_RESP_HIGH) ||
                      (ph_eff == PH_BIT_LOW)  || (ph_eff == PH_BIT_HIGH);
    assign level    = (ph_eff == PH_RESP_HIGH) || (ph_eff == PH_BIT_HIGH);
    assign same     = (i_line == level);

    assign first_fail  = in_pulse && (same ? (tc_eff >= {8'd0, i_cfg.timeout})
                                           : (tc_eff == '0));
    assign pulse_end   = in_pulse && !same && (tc_eff != '0);
    assign bit_inc     = r_bit_idx + 1'b1;
    assign last_bit    = pulse_end && (ph_eff == PH_BIT_HIGH) &&
                         (bit_inc >= BIT_IDX_W'(FRAME_LEN));
    // After a pulse ends, its last sample opens the next pulse at count zero.
    assign second_fail = pulse_end && !last_bit && (i_cfg.timeout == 8'd0);
    assign fail        = first_fail || second_fail;

    assign frame_next = {r_frame[FRAME_LEN-2:0], (tc_eff > {8'd0, r_low_len})};

    swhr_decode u_decode (
        .i_frame       (frame_next),
        .o_status      (dec_status),
        .o_humidity    (dec_hum),
        .o_temperature (dec_temp)
    );

    // Next state
    always_comb begin
        n_phase   = ph_eff;
        n_tick    = tc_eff;
        n_low_len = starting ? 8'd0 : r_low_len;
        n_bit_idx = starting ? '0 : r_bit_idx;
        n_frame   = starting ? '0 : r_frame;
        n_hum     = r_hum;
        n_temp    = r_temp;
        case (ph_eff)
            PH_IDLE: begin
            end
            PH_WAKE: begin
                n_tick = tc_inc[TICK_W-1:0];
                if (tc_inc >= {1'b0, i_cfg.start_low}) begin
                    n_phase = PH_RELEASE;
                    n_tick  = '0;
                end
            end
            PH_RELEASE: begin
                n_tick = tc_inc[TICK_W-1:0];
                if (tc_inc >= {9'd0, i_cfg.release_len}) begin
                    n_phase = PH_RESP_LOW;
                    n_tick  = '0;
                end
            end
            PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
                if (same) begin
                    n_tick = tc_inc[TICK_W-1:0];
                end else begin
                    n_tick = TICK_W'(1);
                    case (ph_eff)
                        PH_RESP_LOW:  n_phase = PH_RESP_HIGH;
                        PH_RESP_HIGH: n_phase = PH_BIT_LOW;
                        PH_BIT_LOW: begin
                            n_phase   = PH_BIT_HIGH;
                            n_low_len = tc_eff[7:0];
                        end
                        default: begin
                            n_phase   = PH_BIT_LOW;
                            n_frame   = frame_next;
                            n_bit_idx = bit_inc;
                        end
                    endcase
                end
                if (last_bit) begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                    if (dec_status == ST_OK) begin
                        n_hum  = dec_hum;
                        n_temp = dec_temp;
                    end
                end
                if (fail) begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        drive  = (ph_eff == PH_WAKE);
        done   = fail || last_bit;
        status = ST_OK;
        if (fail) begin
            status = ST_PULSE;
        end else if (last_bit) begin
            status = dec_status;
        end
    end

    assign o_res.drive_low   = drive;
    assign o_res.busy        = (n_phase != PH_IDLE);
    assign o_res.done        = done;
    assign o_res.status      = status;
    assign o_res.humidity    = n_hum;
    assign o_res.temperature = n_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_low_len <= '0;
            r_bit_idx <= '0;
            r_frame   <= '0;
            r_hum     <= '0;
            r_temp    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_low_len <= n_low_len;
            r_bit_idx <= n_bit_idx;
            r_frame   <= n_frame;
            r_hum     <= n_hum;
            r_temp    <= n_temp;
        end
    end

endmodule

[rtl/single_wire_humidity_sensor_reader.sv]
// Top level of the single-wire humidity sensor reader.
//
//  port group   dir  contents
//  s_axis_*     in   one tick request: line sample and start
//  m_axis_*     out  one result per tick request
//  i_cfg_*      in   register writes: timeout, wake length, release length
//
// Requests pass the input register, then results the output register; one
// request per cycle unless the output stalls, one sequencer step per request.
// The input stage keeps accepting while a result waits in the output register.
// A stalled output holds the input stage once both registers are full.
// Synchronous active-low reset clears the sequencer, results and valid flags.
module single_wire_humidity_sensor_reader import swhr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [0] line_level, [1] start_read
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
    // [20:5] humidity_tenths, [36:21] temperature_tenths
    output logic [39:0]      m_axis_tdata,
    input  logic             i_cfg_wr_en,
    input  t_cfg_idx         i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic    r_in_valid;
    logic    r_line, r_start;
    logic    r_out_valid;
    t_result r_out;
    t_result res;
    t_cfg    r_cfg;
    logic    step;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout     <= TIMEOUT_RST;
            r_cfg.start_low   <= START_LOW_RST;
            r_cfg.release_len <= RELEASE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TIMEOUT:   r_cfg.timeout     <= i_cfg_data[7:0];
                CFG_START_LOW: r_cfg.start_low   <= i_cfg_data;
                CFG_RELEASE:   r_cfg.release_len <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_line  <= s_axis_tdata[0];
            r_start <= s_axis_tdata[1];
        end
    end

    swhr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_line  (r_line),
        .i_start (r_start),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.temperature, r_out.humidity, r_out.status,
                            r_out.done, r_out.busy, r_out.drive_low};

endmodule

[rtl/swhr_checker.sv]
// Port-level checks of the sensor reader, bound to the top level.
`include "assert_macros.svh"

module swhr_checker import swhr_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [39:0]      m_axis_tdata
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `ASSERT_SAME(a_status_idle, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[4:3] == ST_OK, "status without done")
    `ASSERT_SAME(a_drive_busy, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1], "line driven while not busy")
    `ASSERT_SAME(a_done_idle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[2], !m_axis_tdata[1], "busy on finishing result")

endmodule

bind single_wire_humidity_sensor_reader swhr_checker u_swhr_checker (.*);

[tb/tb.sv]
// Testbench for the single-wire humidity sensor reader: per-tick prediction and result checks.
module tb;
    import swhr_pkg::*;

    localparam t_cfg_idx CFG_NONE       = t_cfg_idx'(2'd3);
    localparam int       WATCHDOG_LIMIT = 2000;
    localparam int       HOLD_CYCLES    = 300;
    localparam int       RANDOM_TICKS   = 240;

    typedef enum {BRK_NONE, BRK_TRUNC, BRK_LONG, BRK_MISSING, BRK_NOISE} t_break;
    typedef enum {PULSE_RUN, PULSE_END, PULSE_FAIL} t_pulse;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = '0;      // [0] line_level, [1] start_read
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
    // [20:5] humidity_tenths, [36:21] temperature_tenths
    logic [39:0]      m_axis_tdata;
    logic             i_cfg_wr_en = 1'b0;
    t_cfg_idx         i_cfg_index = CFG_TIMEOUT;
    logic [CFG_W-1:0] i_cfg_data = '0;

    single_wire_humidity_sensor_reader u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // sensor reader state as predicted
    logic [7:0]  cfg_timeout;
    logic [15:0] cfg_start_low;
    logic [7:0]  cfg_release;
    t_phase      ph;
    logic [15:0] tick_cnt;
    logic [7:0]  low_len;
    logic [5:0]  bit_cnt;
    logic [39:0] frame;
    logic [15:0] hum_q;
    logic [15:0] temp_q;
    t_result     pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int errors = 0;
    int ticks_sent = 0;
    int n_results = 0;
    int n_reads = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    function automatic t_pulse sample_pulse(input logic level, input logic line);
        if (line == level) begin
            if (tick_cnt >= 16'(cfg_timeout))
                return PULSE_FAIL;
            tick_cnt++;
            return PULSE_RUN;
        end
        if (tick_cnt == 16'd0)
            return PULSE_FAIL;
        return PULSE_END;
    endfunction

    function automatic t_status decode_frame();
        logic [7:0]  b0, b1, b2, b3, b4, sum;
        logic [15:0] mag;
        {b0, b1, b2, b3, b4} = frame;
        sum = b0 + b1 + b2 + b3;
        if (sum != b4)
            return ST_CHECKSUM;
        if ({b0, b1} == 16'd0)
            return ST_HUM_ZERO;
        mag = {1'b0, b2[6:0], b3};
        hum_q = {b0, b1};
        temp_q = b2[7] ? 16'd0 - mag : mag;
        return ST_OK;
    endfunction

    function automatic void predict_tick(input logic line, input logic start);
        t_result    r;
        t_pulse     pr;
        logic [7:0] len;
        logic       fin;
        logic       level;
        r = '0;
        r.status = ST_OK;
        if (ph == PH_IDLE && start) begin
            ph = PH_WAKE;
            tick_cnt = '0;
            low_len = '0;
            bit_cnt = '0;
            frame = '0;
        end
        case (ph)
            PH_IDLE: ;
            PH_WAKE: begin
                r.drive_low = 1'b1;
                tick_cnt++;
                if (tick_cnt >= cfg_start_low) begin
                    ph = PH_RELEASE;
                    tick_cnt = '0;
                end
            end
            PH_RELEASE: begin
                tick_cnt++;
                if (tick_cnt >= 16'(cfg_release)) begin
                    ph = PH_RESP_LOW;
                    tick_cnt = '0;
                end
            end
            default: begin
                level = (ph == PH_RESP_HIGH || ph == PH_BIT_HIGH);
                pr = sample_pulse(level, line);
                if (pr == PULSE_END) begin
                    len = tick_cnt[7:0];
                    fin = 1'b0;
                    tick_cnt = '0;
                    case (ph)
                        PH_RESP_LOW:  ph = PH_RESP_HIGH;
                        PH_RESP_HIGH: ph = PH_BIT_LOW;
                        PH_BIT_LOW: begin
                            low_len = len;
                            ph = PH_BIT_HIGH;
                        end
                        default: begin
                            frame = {frame[38:0], len > low_len};
                            bit_cnt++;
                            if (bit_cnt >= 6'(FRAME_LEN)) begin
                                fin = 1'b1;
                                r.status = decode_frame();
                                r.done = 1'b1;
                                ph = PH_IDLE;
                            end else begin
                                ph = PH_BIT_LOW;
                            end
                        end
                    endcase
                    if (!fin) begin
                        level = (ph == PH_RESP_HIGH || ph == PH_BIT_HIGH);
                        pr = sample_pulse(level, line);
                    end
                end
                if (pr == PULSE_FAIL) begin
                    r.status = ST_PULSE;
                    r.done = 1'b1;
                    ph = PH_IDLE;
                    tick_cnt = '0;
                end
            end
        endcase
        r.busy = (ph != PH_IDLE);
        r.humidity = hum_q;
        r.temperature = temp_q;
        pending_results.push_back(r);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // start requests sprinkled into a read; the block must ignore them
    function automatic logic stray_start();
        return $urandom_range(3) == 0;
    endfunction

    function automatic logic [39:0] make_frame();
        logic [7:0] b0, b1, b2, b3, b4;
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        b3 = 8'($urandom);
        if ($urandom_range(9) == 0)
            {b0, b1} = 16'd0;
        if ($urandom_range(9) == 0)
            {b2, b3} = 16'h8000;
        b4 = b0 + b1 + b2 + b3;
        if ($urandom_range(7) == 0)
            b4 = b4 ^ 8'($urandom_range(255, 1));
        return {b0, b1, b2, b3, b4};
    endfunction

    task automatic send_tick(input logic line, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, start, line};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_tick(line, start);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_pulse(input logic level, input int len);
        repeat (len) send_tick(level, stray_start());
    endtask

    // one read: wake, release, response pair and 40 bit pairs, optionally broken
    task automatic send_frame(input logic [39:0] bytes, input int maxlen, input int resp_len,
                              input t_break brk);
        int n, lo, hi, cut, long_at;
        send_tick(rand_bit(), 1'b1);
        n = (cfg_start_low == 16'd0) ? 1 : int'(cfg_start_low);
        repeat (n - 1) send_tick(rand_bit(), stray_start());
        n = (cfg_release == 8'd0) ? 1 : int'(cfg_release);
        repeat (n) send_tick(rand_bit(), stray_start());
        if (brk == BRK_MISSING) begin
            send_tick(1'b1, 1'b0);
            return;
        end
        send_pulse(1'b0, (resp_len != 0) ? resp_len : $urandom_range(maxlen, 1));
        send_pulse(1'b1, (resp_len != 0) ? resp_len : $urandom_range(maxlen, 1));
        cut = (brk == BRK_TRUNC) ? $urandom_range(39) : FRAME_LEN;
        long_at = $urandom_range(FRAME_LEN - 1);
        for (int i = 0; i < cut; i++) begin
            if (bytes[FRAME_LEN - 1 - i] && maxlen > 1) begin
                lo = $urandom_range(maxlen - 1, 1);
                hi = $urandom_range(maxlen, lo + 1);
            end else begin
                lo = $urandom_range(maxlen, 1);
                hi = $urandom_range(lo, 1);
            end
            send_pulse(1'b0, lo);
            if (brk == BRK_LONG && i == long_at) begin
                send_pulse(1'b1, cfg_timeout + 1);
                return;
            end
            send_pulse(1'b1, hi);
        end
        if (brk != BRK_TRUNC)
            send_tick(1'b0, rand_bit());
    endtask

    task automatic settle_read();
        while (ph != PH_IDLE)
            send_tick(1'b0, 1'b0);
    endtask

    task automatic wait_idle();
        settle_read();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_TIMEOUT:   cfg_timeout = val[7:0];
            CFG_START_LOW: cfg_start_low = val;
            CFG_RELEASE:   cfg_release = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] tmo, input logic [15:0] wake,
                              input logic [7:0] rel);
        wait_idle();
        cfg_write(CFG_TIMEOUT, {8'($urandom), tmo});
        cfg_write(CFG_START_LOW, wake);
        cfg_write(CFG_RELEASE, {8'($urandom), rel});
    endtask

    task automatic set_idling(input int sender, input int receiver);
        send_idle_pct = sender;
        recv_idle_pct = receiver;
    endtask

    // reset timeout and release length, with a short wake pulse
    task automatic test_reset_values();
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        wait_idle();
        cfg_write(CFG_START_LOW, 16'd2);
        send_frame(40'h02_8C_01_5F_EE, 2, 0, BRK_NONE);
        wait_idle();
    endtask

    task automatic test_corner_settings();
        // zero timeout: wake and release take one tick each, first response sample fails
        set_config(8'd0, 16'd0, 8'd0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        // response low pulse of zero length
        set_config(8'd5, 16'd0, 8'd0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        wait_idle();
        cfg_write(CFG_NONE, 16'hFFFF);
        send_frame(make_frame(), 1, 0, BRK_LONG);
        wait_idle();
    endtask

    task automatic test_frame_contents();
        logic [39:0] frames[3] = '{
            40'hFF_FF_FF_FF_FC,
            40'h00_00_01_00_00,
            40'h01_F4_80_00_75
        };
        set_config(8'd4, 16'd2, 8'd1);
        foreach (frames[k])
            send_frame(frames[k], 2, 0, BRK_NONE);
        wait_idle();
    endtask

    // pulses of exactly the timeout pass, one tick more fails
    task automatic test_pulse_limits();
        set_config(8'd3, 16'd1, 8'd1);
        send_frame(make_frame(), 3, 3, BRK_LONG);
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_config(8'd8, 16'd4, 8'd3);
        set_idling(0, 0);
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        @(negedge i_clk);
        send_frame(make_frame(), 3, 0, BRK_MISSING);
        wait_idle();
        send_frame(make_frame(), 3, 0, BRK_MISSING);
        wait_idle();
        set_idling(30, 70);
    endtask

    task automatic test_random();
        int         target, maxlen;
        logic [7:0] tmo;
        t_break     brk;
        for (int m = 0; m < 3; m++) begin
            case (m)
                0:       set_idling(30, 70);
                1:       set_idling(70, 30);
                default: set_idling(0, 0);
            endcase
            target = ticks_sent + RANDOM_TICKS / 3;
            while (ticks_sent < target) begin
                case ($urandom_range(15))
                    0:       tmo = 8'd0;
                    1, 2, 3: tmo = 8'($urandom_range(3, 1));
                    4:       tmo = 8'd255;
                    default: tmo = 8'($urandom_range(255, 4));
                endcase
                set_config(tmo, 16'($urandom_range(12)), 8'($urandom_range(12)));
                maxlen = (tmo == 8'd0) ? 1 : (tmo < 8'd3) ? int'(tmo) : $urandom_range(3, 2);
                repeat ($urandom_range(2, 1)) begin
                    brk = ($urandom_range(3) != 0) ? BRK_NONE : t_break'($urandom_range(4, 1));
                    if (brk == BRK_NOISE) begin
                        repeat ($urandom_range(40, 5))
                            send_tick(rand_bit(), $urandom_range(7) == 0);
                    end else begin
                        send_frame(make_frame(), maxlen, 0, brk);
                    end
                    settle_read();
                    repeat ($urandom_range(3))
                        send_tick(rand_bit(), 1'b0);
                end
            end
        end
        wait_idle();
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.drive_low = m_axis_tdata[0];
            got.busy = m_axis_tdata[1];
            got.done = m_axis_tdata[2];
            got.status = t_status'(m_axis_tdata[4:3]);
            got.humidity = m_axis_tdata[20:5];
            got.temperature = m_axis_tdata[36:21];
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result with no request pending");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.drive_low !== want.drive_low) begin
                    $error("drive_low: expected %0d, got %0d", want.drive_low, got.drive_low);
                    errors++;
                end
                if (got.busy !== want.busy) begin
                    $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
                    errors++;
                end
                if (got.done !== want.done) begin
                    $error("done_res: expected %0d, got %0d", want.done, got.done);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.humidity !== want.humidity) begin
                    $error("humidity_tenths: expected %0d, got %0d",
                           want.humidity, got.humidity);
                    errors++;
                end
                if (got.temperature !== want.temperature) begin
                    $error("temperature_tenths: expected %0d, got %0d",
                           $signed(want.temperature), $signed(got.temperature));
                    errors++;
                end
                if (want.done) begin
                    n_reads++;
                    status_seen[want.status]++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        cfg_timeout = TIMEOUT_RST;
        cfg_start_low = START_LOW_RST;
        cfg_release = RELEASE_RST;
        ph = PH_IDLE;
        tick_cnt = '0;
        low_len = '0;
        bit_cnt = '0;
        frame = '0;
        hum_q = '0;
        temp_q = '0;
        set_idling(30, 70);
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_corner_settings();
        test_frame_contents();
        test_pulse_limits();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (20) @(negedge i_clk);
        $display("Run covered %0d tick requests and %0d results, %0d finished reads:",
                 ticks_sent, n_results, n_reads);
        $display("  ok %0d, pulse failure %0d, checksum %0d, zero humidity %0d",
                 status_seen[ST_OK], status_seen[ST_PULSE], status_seen[ST_CHECKSUM],
                 status_seen[ST_HUM_ZERO]);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/swhr_pkg.sv
rtl/swhr_decode.sv
rtl/swhr_ctrl.sv
rtl/single_wire_humidity_sensor_reader.sv
rtl/swhr_checker.sv
tb/tb.sv
